// ===== design/fdf_pkg.sv =====
// Package for the first difference filter: register widths, configuration
// register indexes, filter modes and controller states.
// No dependencies; fdf_result_if and first_difference_filter use it.
`default_nettype none

package fdf_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int MODE_W           = 2;
    localparam int TAU_W            = 16;
    localparam int GAIN_W           = 8;
    localparam int OUT_W            = 32;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE = 2'd0,
        REG_TAU  = 2'd1,
        REG_GAIN = 2'd2
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOWPASS     = 2'd0,
        MODE_HIGHPASS    = 2'd1,
        MODE_ENV_LOWPASS = 2'd2,
        MODE_ENV_LINEAR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_MUL_TAU,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== design/fdf_sample_if.sv =====
// Input channel of the first difference filter: valid/ready handshake
// carrying one signed audio sample per transaction. No dependencies.
`default_nettype none

interface fdf_sample_if #(
    parameter int WIDTH = 16
) ();

    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

// ===== design/fdf_result_if.sv =====
// Output channel of the first difference filter: valid/ready handshake
// carrying the filtered value and its saturation flag. Uses fdf_pkg.
`default_nettype none

interface fdf_result_if ();

    logic                            valid;
    logic                            ready;
    logic signed [fdf_pkg::OUT_W-1:0] filtered;
    logic                            saturated;

    modport source (output valid, output filtered, output saturated, input ready);
    modport sink   (input valid, input filtered, input saturated, output ready);

endinterface

`default_nettype wire

// ===== design/fdf_mul.sv =====
// Shift-and-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, added onto a preloaded accumulator.
// No dependencies.
`default_nettype none

module fdf_mul #(
    parameter int ACC_W = 49,
    parameter int MPL_W = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [ACC_W-1:0] mcand,
    input  wire logic        [MPL_W-1:0] mplier,
    input  wire logic signed [ACC_W-1:0] acc_init,
    output logic                         done,
    output logic signed [ACC_W-1:0]      product
);

    localparam int CNT_W = $clog2(MPL_W);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic        [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic        [MPL_W-1:0] mplier_reg, mplier_next;
    logic                    last;

    assign last = (cnt_reg == CNT_W'(MPL_W - 1));

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = acc_init;
            mcand_next  = mcand;
            mplier_next = mplier;
        end
        else if (busy_reg)
        begin
            acc_next    = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== design/fdf_div.sv =====
// Restoring divider on magnitudes, one quotient bit per cycle. The caller
// guarantees that the quotient fits in Q_W bits. No dependencies.
`default_nettype none

module fdf_div #(
    parameter int NUM_W = 48,
    parameter int Q_W   = 32,
    parameter int D_W   = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num_mag,
    input  wire logic [D_W-1:0]   divisor,
    output logic                  done,
    output logic [Q_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [D_W:0]     rem_sh;
    logic [D_W:0]     diff;
    logic             fits;
    logic             last;

    assign rem_sh = {rem_reg, q_reg[Q_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign fits   = ~diff[D_W];
    assign last   = (cnt_reg == CNT_W'(Q_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = D_W'(num_mag >> Q_W);
            q_next    = num_mag[Q_W-1:0];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[D_W-1:0] : rem_sh[D_W-1:0];
            q_next   = {q_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== design/first_difference_filter.sv =====
// First difference filter: lowpass, highpass and envelope modes on a stream
// of signed samples. Uses fdf_pkg, fdf_sample_if, fdf_result_if, fdf_mul, fdf_div.
//
// Usage: samples arrive on the samples channel, one per transaction, and each
// gives exactly one transaction on the results channel (filtered value and a
// saturation flag). Mode, tau and gain are written through cfg_wen, cfg_index and
// cfg_data only while no sample is in flight; the user, not the block, ensures it.
// Datapath: one serial multiplier does gain*x (gain*dx in highpass) and then
// tau*(...), and a restoring divider by tau+1 produces Q bits at one bit per
// cycle, with Q = max(32, SAMPLE_WIDTH + 9). Envelope linear mode skips the
// second multiply and the divide.
// One sample is processed at a time; the result sits in an output register, so
// a new sample is accepted while the receiver has not taken the last result.
// If the receiver stalls, the block holds the next result in its final state
// until the output register frees up.
// Reset clears the previous output and previous sample to zero and sets mode
// to lowpass, tau to 1 and gain to 1.
`default_nettype none

module first_difference_filter #(
    parameter int SAMPLE_WIDTH = fdf_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    fdf_sample_if.sink                              samples,
    fdf_result_if.source                            results,
    input  wire logic                               cfg_wen,
    input  wire logic [fdf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fdf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import fdf_pkg::*;

    localparam int DX_W  = SAMPLE_WIDTH + 1;
    localparam int GX_W  = DX_W + GAIN_W;
    localparam int S_W   = ((OUT_W > GX_W) ? OUT_W : GX_W) + 1;
    localparam int ACC_W = S_W + TAU_W;
    localparam int Q_W   = S_W - 1;
    localparam int R_W   = S_W + 1;
    localparam int D_W   = TAU_W + 1;

    localparam logic signed [R_W-1:0] SAT_MAX = R_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [R_W-1:0] SAT_MIN = ~SAT_MAX;

    state_t                         state_reg, state_next;
    mode_t                          mode_reg;
    logic        [TAU_W-1:0]        tau_reg;
    logic        [GAIN_W-1:0]       gain_reg;
    logic signed [OUT_W-1:0]        prev_output_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [GX_W-1:0]         gx_reg;
    logic                           neg_reg;
    logic                           results_valid_reg;
    logic signed [OUT_W-1:0]        filtered_reg, filtered_next;
    logic                           saturated_reg, saturated_next;

    logic                           samples_ready;
    logic                           accept;
    logic                           finish_load;
    logic signed [DX_W-1:0]         dx;

    logic                           mul_start;
    logic signed [ACC_W-1:0]        mul_mcand;
    logic        [TAU_W-1:0]        mul_mplier;
    logic signed [ACC_W-1:0]        mul_acc;
    logic                           mul_done;
    logic signed [ACC_W-1:0]        mul_product;

    logic                           div_start;
    logic        [ACC_W-1:0]        prod_mag;
    logic        [D_W-1:0]          divisor;
    logic                           div_done;
    logic        [Q_W-1:0]          div_quot;

    logic signed [R_W-1:0]          q_ext;
    logic signed [R_W-1:0]          lp;
    logic signed [R_W-1:0]          gx_ext;
    logic signed [R_W-1:0]          lin;
    logic signed [R_W-1:0]          r;

    assign dx     = DX_W'(samples.sample) - DX_W'(prev_sample_reg);
    assign accept = samples.valid && samples_ready;

    fdf_mul #(
        .ACC_W (ACC_W),
        .MPL_W (TAU_W)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .mcand    (mul_mcand),
        .mplier   (mul_mplier),
        .acc_init (mul_acc),
        .done     (mul_done),
        .product  (mul_product)
    );

    assign prod_mag = mul_product[ACC_W-1] ? -mul_product : mul_product;
    assign divisor  = D_W'(tau_reg) + D_W'(1);

    fdf_div #(
        .NUM_W (ACC_W - 1),
        .Q_W   (Q_W),
        .D_W   (D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_mag  (prod_mag[ACC_W-2:0]),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                    state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:
            begin
                if (mul_done)
                    state_next = (mode_reg == MODE_ENV_LINEAR) ? ST_FINISH : ST_MUL_TAU;
            end
            ST_MUL_TAU:
            begin
                if (mul_done)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!results_valid_reg || results.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        samples_ready = 1'b0;
        mul_start     = 1'b0;
        div_start     = 1'b0;
        finish_load   = 1'b0;
        mul_mcand     = '0;
        mul_mplier    = '0;
        mul_acc       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                samples_ready = 1'b1;
                mul_start     = samples.valid;
                mul_mcand     = (mode_reg == MODE_HIGHPASS) ? ACC_W'(dx)
                                                            : ACC_W'(samples.sample);
                mul_mplier    = TAU_W'(gain_reg);
            end
            ST_MUL_GAIN:
            begin
                mul_start  = mul_done && (mode_reg != MODE_ENV_LINEAR);
                mul_mplier = tau_reg;
                if (mode_reg == MODE_HIGHPASS)
                begin
                    mul_mcand = ACC_W'(prev_output_reg) + mul_product;
                end
                else
                begin
                    mul_mcand = ACC_W'(prev_output_reg);
                    mul_acc   = mul_product;
                end
            end
            ST_MUL_TAU:
            begin
                div_start = mul_done;
            end
            ST_DIV:
            begin
            end
            ST_FINISH:
            begin
                finish_load = !results_valid_reg || results.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        q_ext  = R_W'(div_quot);
        lp     = neg_reg ? -q_ext : q_ext;
        gx_ext = R_W'(gx_reg);
        lin    = R_W'(prev_output_reg) - R_W'(1);
        unique case (mode_reg)
            MODE_LOWPASS,
            MODE_HIGHPASS:    r = lp;
            MODE_ENV_LOWPASS: r = (gx_ext > lp) ? gx_ext : lp;
            MODE_ENV_LINEAR:  r = (gx_ext > lin) ? gx_ext : lin;
            default:          r = lp;
        endcase
        saturated_next = 1'b1;
        priority if (r > SAT_MAX)
            filtered_next = SAT_MAX[OUT_W-1:0];
        else if (r < SAT_MIN)
            filtered_next = SAT_MIN[OUT_W-1:0];
        else
        begin
            filtered_next  = r[OUT_W-1:0];
            saturated_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mode_reg          <= MODE_LOWPASS;
            tau_reg           <= TAU_W'(1);
            gain_reg          <= GAIN_W'(1);
            prev_output_reg   <= '0;
            prev_sample_reg   <= '0;
            results_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_MODE: mode_reg <= mode_t'(cfg_data[MODE_W-1:0]);
                    REG_TAU:  tau_reg  <= cfg_data[TAU_W-1:0];
                    REG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (finish_load)
            begin
                prev_output_reg   <= filtered_next;
                prev_sample_reg   <= x_reg;
                results_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                results_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= samples.sample;
        if ((state_reg == ST_MUL_GAIN) && mul_done)
            gx_reg <= mul_product[GX_W-1:0];
        if (div_start)
            neg_reg <= mul_product[ACC_W-1];
        if (finish_load)
        begin
            filtered_reg  <= filtered_next;
            saturated_reg <= saturated_next;
        end
    end

    assign samples.ready     = samples_ready;
    assign results.valid     = results_valid_reg;
    assign results.filtered  = filtered_reg;
    assign results.saturated = saturated_reg;

endmodule

`default_nettype wire
